// ===== rtl/pds_pkg.sv =====
// Package for the periodic task dispatcher: field widths, item and result
// structs, slot table entry layout, opcode and controller state enums.
// No dependencies.
package pds_pkg;

   localparam int KindW            = 2;
   localparam int SlotW            = 3;
   localparam int PeriodW          = 16;
   localparam int TickW            = 32;
   localparam int TaskSlotsDefault = 8;
   // remainder unit step count must hold TickW itself
   localparam int ModCountW        = $clog2(TickW + 1);

   typedef enum logic [KindW-1:0] {
      KIND_TICK   = 2'd0,
      KIND_CREATE = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_STATE  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [SlotW-1:0]     slot;
      logic [PeriodW-1:0]   period;
      logic                 has_handler;
      logic                 make_ready;
   } req_type;

   typedef struct packed {
      logic [SlotW-1:0]     due_slot;
      logic                 last_of_run;
   } rsp_type;

   // one word of the slot table
   typedef struct packed {
      logic [PeriodW-1:0]   period;
      logic                 ready;
      logic                 handler;
   } task_entry_type;

   localparam int EntryW = $bits(task_entry_type);

   typedef struct packed {
      logic                 done;
      logic                 rem_zero;
   } mod_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDIT,
      ST_READ,
      ST_EVAL,
      ST_DIV,
      ST_PUSH,
      ST_NEXT,
      ST_FLUSH
   } state_type;

endpackage

// ===== rtl/pds_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on pds_pkg for default sizes.
module pds_ram #(
   parameter int WIDTH = pds_pkg::EntryW,
   parameter int DEPTH = pds_pkg::TaskSlotsDefault,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pds_mod.sv =====
// Bit-serial remainder unit: tick count modulo a 16-bit period, one
// quotient bit per cycle. Depends on pds_pkg.
module pds_mod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pds_pkg::TickW-1:0]     dividend,
   input  logic [pds_pkg::PeriodW-1:0]   divisor,
   output pds_pkg::mod_status_type       status
);
   import pds_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [ModCountW-1:0] count_ff, count_in;
   logic [PeriodW-1:0]   rem_ff, rem_in;
   logic [TickW-1:0]     num_ff, num_in;
   logic [PeriodW-1:0]   den_ff, den_in;
   logic [PeriodW:0]     shifted;
   logic [PeriodW:0]     diff;

   always_comb begin
      shifted  = {rem_ff, num_ff[TickW-1]};
      diff     = shifted - {1'b0, den_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = ModCountW'(TickW);
         rem_in   = '0;
         num_in   = dividend;
         den_in   = divisor;
      end else if (busy_ff) begin
         // restoring step: subtract when the shifted remainder reaches the period
         rem_in   = (shifted >= {1'b0, den_ff}) ? diff[PeriodW-1:0] : shifted[PeriodW-1:0];
         num_in   = {num_ff[TickW-2:0], 1'b0};
         count_in = count_ff - 1'b1;
         if (count_ff == ModCountW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
   end

   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

endmodule

// ===== rtl/periodic_task_dispatcher.sv =====
// Periodic task dispatcher. Create, delete and set-state transfers edit one
// slot of the task table and give no result: create is a single write, delete
// and set-state a read, modify, write of the table RAM. A tick transfer bumps
// the 32-bit tick counter, then walks every slot in order: each slot is read
// and evaluated, each ready slot with a handler and nonzero period goes through
// the bit-serial remainder unit, each due slot is pushed, and the walk ends in
// the flush state; rsp_stall can hold the walk while a due slot waits in the
// output register. The remainder unit sets the pace. Due slot indices leave
// through an output register, the last one of a tick marked; req_stall stays
// high until the walk is done.
// Depends on pds_pkg, pds_ram and pds_mod.
module periodic_task_dispatcher #(
   parameter int TASK_SLOTS = pds_pkg::TaskSlotsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pds_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pds_pkg::rsp_type  rsp_payload
);
   import pds_pkg::*;

   localparam int SlotAw = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int WideW  = ((SlotAw > SlotW) ? SlotAw : SlotW) + 1;

   state_type           state_ff, state_in;
   logic [TickW-1:0]    tick_ff, tick_in;
   logic [SlotAw-1:0]   scan_ff, scan_in;
   kind_type            kind_ff, kind_in;
   logic                make_ready_ff, make_ready_in;
   logic [SlotAw-1:0]   edit_addr_ff, edit_addr_in;
   logic [SlotAw-1:0]   rd_addr_ff, rd_addr_in;
   logic [TASK_SLOTS-1:0] valid_ff, valid_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [SlotW-1:0]    pend_slot_ff, pend_slot_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_ff, out_in;

   logic                ram_wr_en, ram_rd_en;
   logic [SlotAw-1:0]   ram_wr_addr, ram_rd_addr;
   logic [EntryW-1:0]   ram_wr_data, ram_rd_data;
   task_entry_type      entry_q, entry_w;

   logic                mod_start;
   mod_status_type      mod_st;

   logic [WideW-1:0]    slot_wide;
   logic                in_range;
   logic [SlotAw-1:0]   req_addr;
   logic [SlotW-1:0]    scan_slot;
   logic                eligible;
   logic                out_free;

   pds_ram #(
      .WIDTH (EntryW),
      .DEPTH (TASK_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pds_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (tick_ff),
      .divisor  (entry_q.period),
      .status   (mod_st)
   );

   // entries never written read as all zeros
   assign entry_q   = valid_ff[rd_addr_ff] ? task_entry_type'(ram_rd_data) : '0;
   assign slot_wide = WideW'(req_payload.slot);
   assign in_range  = (slot_wide < WideW'(TASK_SLOTS));
   assign req_addr  = SlotAw'(slot_wide);
   assign scan_slot = SlotW'(WideW'(scan_ff));
   assign eligible  = entry_q.ready && entry_q.handler && (entry_q.period != '0);
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      tick_in       = tick_ff;
      scan_in       = scan_ff;
      kind_in       = kind_ff;
      make_ready_in = make_ready_ff;
      edit_addr_in  = edit_addr_ff;
      rd_addr_in    = rd_addr_ff;
      valid_in      = valid_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_in        = out_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = edit_addr_ff;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = scan_ff;
      entry_w       = entry_q;
      mod_start     = 1'b0;
      req_stall     = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_payload.kind == KIND_TICK) begin
                  tick_in  = TickW'(tick_ff + 1'b1);
                  scan_in  = '0;
                  state_in = ST_READ;
               end else if (in_range) begin
                  edit_addr_in  = req_addr;
                  kind_in       = req_payload.kind;
                  make_ready_in = req_payload.make_ready;
                  if (req_payload.kind == KIND_CREATE) begin
                     entry_w.period   = req_payload.period;
                     entry_w.ready    = 1'b1;
                     entry_w.handler  = req_payload.has_handler;
                     ram_wr_en        = 1'b1;
                     ram_wr_addr      = req_addr;
                     ram_wr_data      = entry_w;
                     valid_in[req_addr] = 1'b1;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = req_addr;
                     rd_addr_in  = req_addr;
                     state_in    = ST_EDIT;
                  end
               end
            end
         end
         ST_EDIT: begin
            priority if (kind_ff == KIND_DELETE) begin
               entry_w.handler = 1'b0;
            end else begin
               entry_w.ready = make_ready_ff;
            end
            ram_wr_en              = 1'b1;
            ram_wr_addr            = edit_addr_ff;
            ram_wr_data            = entry_w;
            valid_in[edit_addr_ff] = 1'b1;
            state_in               = ST_IDLE;
         end
         ST_READ: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = scan_ff;
            rd_addr_in  = scan_ff;
            state_in    = ST_EVAL;
         end
         ST_EVAL: begin
            if (eligible) begin
               mod_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in  = ST_NEXT;
            end
         end
         ST_DIV: begin
            if (mod_st.done) begin
               state_in = mod_st.rem_zero ? ST_PUSH : ST_NEXT;
            end
         end
         ST_PUSH: begin
            // hold the newest due slot back until we know whether it is the last
            if (out_free) begin
               if (pend_valid_ff) begin
                  out_valid_in       = 1'b1;
                  out_in.due_slot    = pend_slot_ff;
                  out_in.last_of_run = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_slot_in  = scan_slot;
               state_in      = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (scan_ff == SlotAw'(TASK_SLOTS - 1)) begin
               state_in = ST_FLUSH;
            end else begin
               scan_in  = SlotAw'(scan_ff + 1'b1);
               state_in = ST_READ;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in       = 1'b1;
               out_in.due_slot    = pend_slot_ff;
               out_in.last_of_run = 1'b1;
               pend_valid_in      = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_ff       <= '0;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      scan_ff       <= scan_in;
      kind_ff       <= kind_in;
      make_ready_ff <= make_ready_in;
      edit_addr_ff  <= edit_addr_in;
      rd_addr_ff    <= rd_addr_in;
      pend_slot_ff  <= pend_slot_in;
      out_ff        <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

// ===== rtl/pds_checker.sv =====
// Port-level checks for the periodic task dispatcher, bound to the top level.
// Depends on pds_pkg.
module pds_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input pds_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pds_pkg::rsp_type rsp_payload
);
   import pds_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // edits never produce a result
   a_edit_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.kind != KIND_TICK |=> !$rose(rsp_valid))
      else $error("result appeared after an edit transfer");

   // create is a single write and leaves the request side free in the next cycle
   a_create_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.kind == KIND_CREATE |=> !req_stall)
      else $error("create did not finish in one cycle");

   // a tick always starts a slot walk
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.kind == KIND_TICK |=> req_stall)
      else $error("tick transfer did not start a walk");

endmodule

bind periodic_task_dispatcher pds_checker u_pds_checker (.*);
